### rtl/prqs_pkg.sv
// ----------------------------------------------------------------------------
// Process ready queue sorter package
// Shared types, widths and codes for the ready queue, its store and control.
// ----------------------------------------------------------------------------
package prqs_pkg;

   // Number of record slots in the queue.
   localparam int QUEUE_DEPTH = 16;
   // Slot index width and record count width (the count can reach the depth).
   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Command codes.
   typedef enum logic [1:0] {
      CMD_ENQUEUE  = 2'd0,
      CMD_DEQUEUE  = 2'd1,
      CMD_SORT_ARR = 2'd2,
      CMD_SORT_DUR = 2'd3
   } cmd_type;

   // Result status codes.
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   // One stored process record.
   typedef struct packed {
      logic [15:0] pid;
      logic [15:0] dur;
      logic [15:0] arr;
   } rec_type;

   // Command transaction payload.
   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] process_id;
      logic [15:0] time_to_complete;
      logic [15:0] time_of_arrival;
   } req_type;

   // Result transaction payload.
   typedef struct packed {
      logic [1:0]  status;
      logic        record_valid;
      logic [15:0] out_process_id;
      logic [15:0] out_duration;
      logic [15:0] out_arrival;
      logic [4:0]  held_count;
   } rsp_type;

   // Access request from the control to the record store.
   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      rec_type          wdata;
      logic [IDX_W-1:0] raddr;
   } mem_req_type;

   // Control status seen by the top level.
   typedef struct packed {
      logic             idle;
      logic [CNT_W-1:0] count;
   } ctrl_stat_type;

endpackage

### rtl/prqs_store.sv
// ----------------------------------------------------------------------------
// Process ready queue record store
// One write port and one registered read port over the circular record buffer.
// ----------------------------------------------------------------------------
module prqs_store
   import prqs_pkg::*;
(
   input  logic        clock,
   input  mem_req_type mem_req,
   output rec_type     rd_data
);

   rec_type mem [QUEUE_DEPTH];
   rec_type rd_data_ff;

   // Write at the requested slot; the read data is registered and appears in the cycle after the address.
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rd_data_ff <= mem[mem_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/prqs_ctrl.sv
// ----------------------------------------------------------------------------
// Process ready queue control
// Runs enqueue, dequeue and the stable in-place insertion sort over the store.
// ----------------------------------------------------------------------------
module prqs_ctrl
   import prqs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  req_type       req_payload,
   input  logic          out_free,
   input  rec_type       rd_data,
   output mem_req_type   mem_req,
   output logic          res_push,
   output rsp_type       res_out,
   output ctrl_stat_type stat
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DEQ_RD = 6'b000010,
      ST_LOAD   = 6'b000100,
      ST_CMP    = 6'b001000,
      ST_PLACE  = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0] i_next;
   logic             by_arr_ff, by_arr_in;
   rec_type          item_ff, item_in;
   rsp_type          res_ff, res_in;

   // Physical slot of the record at a given offset from the head.
   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                             input logic [CNT_W-1:0] off);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(off);
      if (sum >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
         sum = sum - (CNT_W + 1)'(QUEUE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   // Sort key of a record.
   function automatic logic [15:0] key_of(input rec_type r, input logic by_arr);
      return by_arr ? r.arr : r.dur;
   endfunction

   assign i_next = i_ff + CNT_W'(1);

   // Next state and store access.
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      by_arr_in     = by_arr_ff;
      item_in       = item_ff;
      res_in        = res_ff;
      mem_req       = '0;
      res_push      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_in = '0;
               unique case (cmd_type'(req_payload.command))
                  CMD_ENQUEUE: begin
                     if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                        res_in.status = STAT_FULL;
                     end else begin
                        mem_req.we        = 1'b1;
                        mem_req.waddr     = phys(head_ff, count_ff);
                        mem_req.wdata.pid = req_payload.process_id;
                        mem_req.wdata.dur = req_payload.time_to_complete;
                        mem_req.wdata.arr = req_payload.time_of_arrival;
                        count_in          = count_ff + CNT_W'(1);
                     end
                     state_in = ST_FINISH;
                  end
                  CMD_DEQUEUE: begin
                     if (count_ff == '0) begin
                        res_in.status = STAT_EMPTY;
                        state_in      = ST_FINISH;
                     end else begin
                        mem_req.raddr = head_ff;
                        state_in      = ST_DEQ_RD;
                     end
                  end
                  CMD_SORT_ARR, CMD_SORT_DUR: begin
                     by_arr_in = (cmd_type'(req_payload.command) == CMD_SORT_ARR);
                     if (count_ff < CNT_W'(2)) begin
                        state_in = ST_FINISH;
                     end else begin
                        i_in          = CNT_W'(1);
                        mem_req.raddr = phys(head_ff, CNT_W'(1));
                        state_in      = ST_LOAD;
                     end
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end

         // Head record read back: hand it out and retire the slot.
         ST_DEQ_RD: begin
            res_in.record_valid   = 1'b1;
            res_in.out_process_id = rd_data.pid;
            res_in.out_duration   = rd_data.dur;
            res_in.out_arrival    = rd_data.arr;
            head_in  = (head_ff == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
            count_in = count_ff - CNT_W'(1);
            state_in = ST_FINISH;
         end

         // Record to insert has arrived; fetch its left neighbour.
         ST_LOAD: begin
            item_in       = rd_data;
            j_in          = i_ff;
            mem_req.raddr = phys(head_ff, i_ff - CNT_W'(1));
            state_in      = ST_CMP;
         end

         // Shift a strictly greater neighbour right, or drop the record in.
         ST_CMP: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = phys(head_ff, j_ff);
            if (key_of(rd_data, by_arr_ff) > key_of(item_ff, by_arr_ff)) begin
               mem_req.wdata = rd_data;
               j_in          = j_ff - CNT_W'(1);
               if (j_ff == CNT_W'(1)) begin
                  state_in = ST_PLACE;
               end else begin
                  mem_req.raddr = phys(head_ff, j_ff - CNT_W'(2));
               end
            end else begin
               mem_req.wdata = item_ff;
               i_in          = i_next;
               if (i_next == count_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  mem_req.raddr = phys(head_ff, i_next);
                  state_in      = ST_LOAD;
               end
            end
         end

         // The record belongs at the head of the queue.
         ST_PLACE: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = phys(head_ff, j_ff);
            mem_req.wdata = item_ff;
            i_in          = i_next;
            if (i_next == count_ff) begin
               state_in = ST_FINISH;
            end else begin
               mem_req.raddr = phys(head_ff, i_next);
               state_in      = ST_LOAD;
            end
         end

         // Pass the result on once the output register can take it.
         ST_FINISH: begin
            if (out_free) begin
               res_push = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Working registers of the sort and the pending result.
   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      j_ff      <= j_in;
      by_arr_ff <= by_arr_in;
      item_ff   <= item_in;
      res_ff    <= res_in;
   end

   // The count is final by the time the result is passed on.
   always_comb begin
      res_out            = res_ff;
      res_out.held_count = 5'(count_ff);
   end

   assign stat.idle  = (state_ff == ST_IDLE);
   assign stat.count = count_ff;

endmodule

### rtl/process_ready_queue_sorter_top.sv
// ----------------------------------------------------------------------------
// Process ready queue sorter
// Bounded FIFO of process records with stable sort by arrival or duration.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the req_ channel (valid and stall) and each one gives
//   exactly one transaction on the rsp_ channel: status, the dequeued record
//   where there is one, and the number of records held afterwards.
//   One command is handled at a time; req_stall is high while it runs.
//   Enqueue passes from idle straight to the finish state; dequeue goes
//   through a read state first, since the record store has a registered
//   read port; the response is then loaded into the output register.
//   A sort of n records walks the store with an insertion pass: it goes
//   straight to the finish state when n is below two; otherwise each record
//   is loaded, its strictly greater left neighbours are shifted right, and it is placed.
//   The result sits in an output register; the next command is accepted
//   while it waits. If rsp_stall holds it, a finished command waits inside
//   the block and further commands are stalled.
//   Reset empties the queue and clears the head pointer; the store contents
//   are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module process_ready_queue_sorter_top
   import prqs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   mem_req_type   mem_req;
   rec_type       rd_data;
   ctrl_stat_type stat;
   rsp_type       res_out;
   logic          res_push;
   logic          out_free;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_payload_ff;

   prqs_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   prqs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .out_free    (out_free),
      .rd_data     (rd_data),
      .mem_req     (mem_req),
      .res_push    (res_push),
      .res_out     (res_out),
      .stat        (stat)
   );

   assign req_stall = !stat.idle;

   // Output register: loads when empty or when its transaction is taken.
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = res_push || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         rsp_payload_ff <= res_out;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A result is only passed on when the output register has room.
   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      res_push |-> out_free)
      else $error("result pushed into an occupied output register");

   // The record count never exceeds the queue depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      stat.count <= CNT_W'(QUEUE_DEPTH))
      else $error("record count beyond queue depth");

   // An accepted command keeps the control busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("command accepted without the control leaving idle");

   // A dequeued record is always reported with ok status.
   a_record_ok: assert property (@(posedge clock) disable iff (reset)
      (res_push && res_out.record_valid) |-> (res_out.status == STAT_OK))
      else $error("record returned with an error status");

endmodule
